// File: src/multi_stream_lcg_bank_unit_macros.svh
// assertion macros for the multi-stream lcg bank
// used by the top level, no other dependencies
`ifndef MULTI_STREAM_LCG_BANK_UNIT_MACROS_SVH
`define MULTI_STREAM_LCG_BANK_UNIT_MACROS_SVH

// same-cycle implication under async active-low reset
`define MSL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under async active-low reset
`define MSL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/msl_pkg.sv
// shared types and constants of the multi-stream lcg bank
// no dependencies
package msl_pkg;

	localparam int CMD_W    = 3;
	localparam int STREAM_W = 4;
	localparam int WORD_W   = 32;

	typedef logic [CMD_W-1:0]    cmd_t;
	typedef logic [STREAM_W-1:0] stream_t;
	typedef logic [WORD_W-1:0]   word_t;

	localparam word_t LCG_MUL = 32'h41c6_4e6d;
	localparam word_t LCG_ADD = 32'h0000_3039;
	localparam int DRAW_SHIFT = 16;
	localparam int DRAW_W     = 15;

	localparam cmd_t OP_DRAW      = 3'd0;
	localparam cmd_t OP_SEED      = 3'd1;
	localparam cmd_t OP_SET_STATE = 3'd2;
	localparam cmd_t OP_GET_STATE = 3'd3;
	localparam cmd_t OP_GET_COUNT = 3'd4;
	localparam cmd_t OP_SET_COUNT = 3'd5;

endpackage

// File: src/msl_mem.sv
// one-read one-write bank memory with a registered read port
// entries never written read as zero; depends on msl_pkg
module msl_mem #(
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rd_en,
	input  logic [AW-1:0]  rd_addr,
	output msl_pkg::word_t rd_data,
	input  logic           wr_en,
	input  logic [AW-1:0]  wr_addr,
	input  msl_pkg::word_t wr_data
);
	import msl_pkg::*;

	word_t            mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	word_t            rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// reset value shows through until the entry is written
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= valid_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: src/msl_step.sv
// two-stage lcg step: low word of state * multiplier, then + increment
// depends on msl_pkg
module msl_step (
	input  logic           clk,
	input  msl_pkg::word_t word,
	output msl_pkg::word_t next_word
);
	import msl_pkg::*;

	logic [2*WORD_W-1:0] prod_full;
	word_t               prod_s1;
	word_t               next_s2;

	assign prod_full = word * LCG_MUL;

	always_ff @(posedge clk) begin
		prod_s1 <= prod_full[WORD_W-1:0];
		next_s2 <= prod_s1 + LCG_ADD;
	end

	assign next_word = next_s2;

endmodule

// File: src/multi_stream_lcg_bank_unit.sv
// top level of the multi-stream lcg bank: command sequencer and write-back
// depends on msl_pkg, msl_mem, msl_step and the assertion macro header
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------
//  command  | start / busy       | cmd, stream, value
//  result   | done (one cycle)   | result, ok
//
// an item is taken when start is high and busy is low; busy then stays high
// through read, multiply, and add and write-back, so no new item is taken
// until write-back ends, a limit set by the two-stage multiply-add loop
// through the state memory. done pulses in the cycle after write-back.
// reset clears the per-entry valid bits at once; no clearing pass.
// results cannot be stalled.
`include "multi_stream_lcg_bank_unit_macros.svh"

module multi_stream_lcg_bank_unit #(
	parameter int STREAMS = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  msl_pkg::cmd_t    cmd,
	input  msl_pkg::stream_t stream,
	input  msl_pkg::word_t   value,
	output logic             done,
	output msl_pkg::word_t   result,
	output logic             ok
);
	import msl_pkg::*;

	localparam int AW = (STREAMS > 1) ? $clog2(STREAMS) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_WB   = 2'd3;

	logic [1:0]    state_q;
	logic          accept;
	logic          in_valid;
	logic [AW-1:0] in_addr;

	cmd_t          cmd_q;
	logic          valid_q;
	logic [AW-1:0] addr_q;
	word_t         value_q;

	word_t word_rd, count_rd, next_word;
	logic  word_we, count_we;
	word_t word_wdata, count_wdata;
	word_t result_d;
	logic  ok_d;

	logic  done_q, ok_q;
	word_t result_q;

	assign accept   = start && !busy;
	assign busy     = (state_q != ST_IDLE);
	assign in_valid = {1'b0, stream} < (STREAM_W + 1)'(STREAMS);
	assign in_addr  = in_valid ? stream[AW-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_RD;
				ST_RD:   state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_WB;
				ST_WB:   state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd;
			valid_q <= in_valid;
			addr_q  <= in_addr;
			value_q <= value;
		end
	end

	msl_mem #(.DEPTH(STREAMS)) u_words (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (in_addr),
		.rd_data (word_rd),
		.wr_en   (word_we),
		.wr_addr (addr_q),
		.wr_data (word_wdata)
	);

	msl_mem #(.DEPTH(STREAMS)) u_counts (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (in_addr),
		.rd_data (count_rd),
		.wr_en   (count_we),
		.wr_addr (addr_q),
		.wr_data (count_wdata)
	);

	msl_step u_step (
		.clk       (clk),
		.word      (word_rd),
		.next_word (next_word)
	);

	// write-back and result select, all in the last busy cycle
	always_comb begin
		word_we     = 1'b0;
		count_we    = 1'b0;
		word_wdata  = value_q;
		count_wdata = value_q;
		result_d    = '0;
		ok_d        = 1'b1;
		if (state_q == ST_WB) begin
			unique case (cmd_q)
				OP_DRAW: begin
					word_we     = 1'b1;
					word_wdata  = next_word;
					count_we    = 1'b1;
					count_wdata = count_rd + 32'd1;
					result_d    = {{(WORD_W - DRAW_W){1'b0}},
						next_word[DRAW_SHIFT +: DRAW_W]};
				end
				OP_SEED: begin
					word_we = 1'b1;
				end
				OP_SET_STATE: begin
					word_we = valid_q;
					ok_d    = valid_q;
				end
				OP_GET_STATE: begin
					result_d = valid_q ? word_rd : '0;
					ok_d     = valid_q;
				end
				OP_GET_COUNT: begin
					result_d = count_rd;
				end
				OP_SET_COUNT: begin
					count_we = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_WB);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WB) begin
			result_q <= result_d;
			ok_q     <= ok_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;
	assign ok     = ok_q;

	`MSL_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy && state_q == ST_RD,
		"accepted item did not start the read")
	`MSL_ASSERT_NEXT(a_wb_done, clk, arst_n, state_q == ST_WB, done && !busy,
		"write-back not followed by a result strobe")
	`MSL_ASSERT_NOW(a_done_idle, clk, arst_n, done, state_q == ST_IDLE,
		"result strobe while still busy")
	`MSL_ASSERT_NOW(a_refused_zero, clk, arst_n, done && !ok, result == '0,
		"refused item returned a nonzero result")
	`MSL_ASSERT_NOW(a_draw_width, clk, arst_n, done && cmd_q == OP_DRAW,
		result[WORD_W-1:DRAW_W] == '0, "draw result wider than 15 bits")

endmodule
